### rtl/svgpi_pkg.sv
`timescale 1ns / 1ps

package svgpi_pkg;

	// Token kinds on the input side.
	localparam logic [1:0] TK_NUMBER  = 2'd0;
	localparam logic [1:0] TK_COMMAND = 2'd1;
	localparam logic [1:0] TK_END     = 2'd2;

	// Segment kinds on the output side.
	localparam logic [1:0] SEG_MOVE  = 2'd0;
	localparam logic [1:0] SEG_LINE  = 2'd1;
	localparam logic [1:0] SEG_CLOSE = 2'd2;

	// Command letters (ASCII).
	localparam logic [7:0] LTR_M_UP = 8'h4D;
	localparam logic [7:0] LTR_M_LO = 8'h6D;
	localparam logic [7:0] LTR_L_UP = 8'h4C;
	localparam logic [7:0] LTR_L_LO = 8'h6C;
	localparam logic [7:0] LTR_H_UP = 8'h48;
	localparam logic [7:0] LTR_H_LO = 8'h68;
	localparam logic [7:0] LTR_V_UP = 8'h56;
	localparam logic [7:0] LTR_V_LO = 8'h76;
	localparam logic [7:0] LTR_Z_UP = 8'h5A;
	localparam logic [7:0] LTR_Z_LO = 8'h7A;
	localparam logic [7:0] LTR_NONE = 8'h00;

	// Operations passed from the classifier to the executor.
	typedef enum logic [3:0] {
		OP_MOVE_ABS,
		OP_MOVE_REL,
		OP_LINE_ABS,
		OP_LINE_REL,
		OP_H_ABS,
		OP_H_REL,
		OP_V_ABS,
		OP_V_REL,
		OP_CLOSE,
		OP_CLEAR
	} op_kind_t;

	localparam int OP_KIND_W = $bits(op_kind_t);

	// Control handed from the classifier to the queue.
	typedef struct packed {
		logic     push;
		op_kind_t kind;
	} front_ctl_t;

endpackage

### rtl/svgpi_front.sv
`timescale 1ns / 1ps

module svgpi_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    token_kind,
	input  logic [7:0]                    command_letter,
	input  logic [31:0]                   number_value,
	output svgpi_pkg::front_ctl_t         ctl,
	output logic [COORD_WIDTH-1:0]        op_a,
	output logic [COORD_WIDTH-1:0]        op_b
);
	import svgpi_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int WW = (CW > 32) ? CW : 32;
	localparam logic signed [WW-1:0] CMAX = (WW'(1) << (CW - 1)) - WW'(1);
	localparam logic signed [WW-1:0] CMIN = ~CMAX;

	logic [7:0]          active_q, active_d;
	logic                hold_q, hold_d;
	logic [CW-1:0]       held_q, held_d;
	logic signed [WW-1:0] num_w;
	logic signed [WW-1:0] num_sat;
	logic [CW-1:0]       num_c;

	// Bring the incoming number into the coordinate range.
	always_comb begin
		num_w = WW'($signed(number_value));
		if (num_w > CMAX) begin
			num_sat = CMAX;
		end else if (num_w < CMIN) begin
			num_sat = CMIN;
		end else begin
			num_sat = num_w;
		end
		num_c = num_sat[CW-1:0];
	end

	// Classify the token and track the command and pair state.
	always_comb begin
		active_d  = active_q;
		hold_d    = hold_q;
		held_d    = held_q;
		ctl.push  = 1'b0;
		ctl.kind  = OP_CLEAR;
		op_a      = num_c;
		op_b      = '0;
		if (accept) begin
			case (token_kind)
				TK_END: begin
					active_d = LTR_NONE;
					hold_d   = 1'b0;
					held_d   = '0;
					ctl.push = 1'b1;
					ctl.kind = OP_CLEAR;
				end
				TK_COMMAND: begin
					if (hold_q) begin
						// A letter after a lone x drops both.
						hold_d = 1'b0;
						held_d = '0;
					end else begin
						active_d = command_letter;
						if (command_letter == LTR_Z_UP || command_letter == LTR_Z_LO) begin
							ctl.push = 1'b1;
							ctl.kind = OP_CLOSE;
						end
					end
				end
				TK_NUMBER: begin
					case (active_q) inside
						LTR_M_UP, LTR_M_LO, LTR_L_UP, LTR_L_LO: begin
							if (!hold_q) begin
								held_d = num_c;
								hold_d = 1'b1;
							end else begin
								hold_d   = 1'b0;
								held_d   = '0;
								op_a     = held_q;
								op_b     = num_c;
								ctl.push = 1'b1;
								case (active_q)
									LTR_M_UP: begin
										ctl.kind = OP_MOVE_ABS;
										active_d = LTR_L_UP;
									end
									LTR_M_LO: begin
										ctl.kind = OP_MOVE_REL;
										active_d = LTR_L_LO;
									end
									LTR_L_UP: ctl.kind = OP_LINE_ABS;
									default:  ctl.kind = OP_LINE_REL;
								endcase
							end
						end
						LTR_H_UP: begin
							ctl.push = 1'b1;
							ctl.kind = OP_H_ABS;
						end
						LTR_H_LO: begin
							ctl.push = 1'b1;
							ctl.kind = OP_H_REL;
						end
						LTR_V_UP: begin
							ctl.push = 1'b1;
							ctl.kind = OP_V_ABS;
						end
						LTR_V_LO: begin
							ctl.push = 1'b1;
							ctl.kind = OP_V_REL;
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// Classifier state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= LTR_NONE;
			hold_q   <= 1'b0;
			held_q   <= '0;
		end else begin
			active_q <= active_d;
			hold_q   <= hold_d;
			held_q   <= held_d;
		end
	end

endmodule

### rtl/svgpi_queue.sv
`timescale 1ns / 1ps

module svgpi_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty,
	output logic             full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNTW'(DEPTH));
	assign pop_data  = mem[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

endmodule

### rtl/svgpi_back.sv
`timescale 1ns / 1ps

module svgpi_back #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   op_valid,
	input  svgpi_pkg::op_kind_t    op_kind,
	input  logic [COORD_WIDTH-1:0] op_a,
	input  logic [COORD_WIDTH-1:0] op_b,
	output logic                   op_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             out_kind,
	output logic [31:0]            out_x,
	output logic [31:0]            out_y
);
	import svgpi_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int WW = (CW > 32) ? CW : 32;
	localparam logic signed [WW-1:0] O_MAX = (WW'(1) << 31) - WW'(1);
	localparam logic signed [WW-1:0] O_MIN = ~O_MAX;

	logic [CW-1:0] cur_x_q, cur_y_q, start_x_q, start_y_q;
	logic [CW-1:0] nx, ny, sum_x, sum_y;
	logic          set_start, emit;
	logic [1:0]    seg;
	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [31:0]   out_x_q, out_y_q;

	// Saturating add at the coordinate width.
	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {a[CW-1], a} + {b[CW-1], b};
		if (s[CW] != s[CW-1]) begin
			return s[CW] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
		end
		return s[CW-1:0];
	endfunction

	// Clamp a coordinate to the 32-bit output range.
	function automatic logic [31:0] to_out(input logic [CW-1:0] v);
		logic signed [WW-1:0] w;
		w = WW'($signed(v));
		if (w > O_MAX) begin
			w = O_MAX;
		end else if (w < O_MIN) begin
			w = O_MIN;
		end
		return w[31:0];
	endfunction

	assign sum_x = sat_add(cur_x_q, op_a);
	assign sum_y = sat_add(cur_y_q, (op_kind == OP_V_REL) ? op_a : op_b);

	// Take the next operation when the output register is free or draining.
	assign op_pop = op_valid && (!out_valid_q || out_ready);

	// Next current point for the operation at the queue head.
	always_comb begin
		nx        = cur_x_q;
		ny        = cur_y_q;
		set_start = 1'b0;
		emit      = 1'b1;
		seg       = SEG_LINE;
		case (op_kind)
			OP_MOVE_ABS: begin
				nx        = op_a;
				ny        = op_b;
				set_start = 1'b1;
				seg       = SEG_MOVE;
			end
			OP_MOVE_REL: begin
				nx        = sum_x;
				ny        = sum_y;
				set_start = 1'b1;
				seg       = SEG_MOVE;
			end
			OP_LINE_ABS: begin
				nx = op_a;
				ny = op_b;
			end
			OP_LINE_REL: begin
				nx = sum_x;
				ny = sum_y;
			end
			OP_H_ABS: nx = op_a;
			OP_H_REL: nx = sum_x;
			OP_V_ABS: ny = op_a;
			OP_V_REL: ny = sum_y;
			OP_CLOSE: begin
				nx  = start_x_q;
				ny  = start_y_q;
				seg = SEG_CLOSE;
			end
			default: begin
				nx   = '0;
				ny   = '0;
				emit = 1'b0;
			end
		endcase
	end

	// Pen state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (op_pop) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			if (set_start) begin
				start_x_q <= nx;
				start_y_q <= ny;
			end else if (op_kind == OP_CLEAR) begin
				start_x_q <= '0;
				start_y_q <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op_pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && emit) begin
			out_kind_q <= seg;
			out_x_q    <= to_out(nx);
			out_y_q    <= to_out(ny);
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op_kind == OP_CLEAR) |=> (cur_x_q == '0 && start_y_q == '0))
		else $error("end of path did not clear the pen state");

	a_close_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op_kind == OP_CLOSE) |=> (cur_x_q == start_x_q && cur_y_q == start_y_q))
		else $error("close did not return to the subpath start");

	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !op_pop)
		else $error("operation taken while the output word is stalled");

endmodule

### rtl/svg_path_subset_interpreter.sv
`timescale 1ns / 1ps

// Channel | Dir | tdata (low bit up)                       | tuser
// s_*     | in  | command_letter[7:0], number_value[39:8]  | token_kind[1:0]
// m_*     | out | point_x[31:0], point_y[63:32]            | segment_kind[1:0]
//
// One token is taken per cycle while the queue is not full; a segment word leaves through
// the classifier, a four-entry queue and then the executor's output register.
// The executor holds a single saturating adder pair for its relative operations.
// arst_n clears the pen state, the command state and the queue; no clearing pass is needed.
// A stall on m_tready fills the queue; s_tready drops only when the queue is full.

module svg_path_subset_interpreter #(
	parameter int COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // command_letter[7:0], number_value[39:8]
	input  logic [1:0]  s_tuser,   // token_kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // point_x[31:0], point_y[63:32]
	output logic [1:0]  m_tuser    // segment_kind[1:0]
);
	import svgpi_pkg::*;

	localparam int QW = OP_KIND_W + 2 * COORD_WIDTH;
	localparam int QDEPTH = 4;

	front_ctl_t             ctl;
	logic [COORD_WIDTH-1:0] f_a, f_b;
	logic [QW-1:0]          q_head;
	logic                   q_valid, q_full, q_pop;
	op_kind_t               b_kind;
	logic [COORD_WIDTH-1:0] b_a, b_b;
	logic                   accept;
	logic [31:0]            px, py;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	svgpi_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.token_kind    (s_tuser),
		.command_letter(s_tdata[7:0]),
		.number_value  (s_tdata[39:8]),
		.ctl           (ctl),
		.op_a          (f_a),
		.op_b          (f_b)
	);

	svgpi_queue #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ctl.push),
		.push_data({f_b, f_a, ctl.kind}),
		.pop      (q_pop),
		.pop_data (q_head),
		.not_empty(q_valid),
		.full     (q_full)
	);

	assign b_kind = op_kind_t'(q_head[OP_KIND_W-1:0]);
	assign b_a    = q_head[OP_KIND_W +: COORD_WIDTH];
	assign b_b    = q_head[OP_KIND_W + COORD_WIDTH +: COORD_WIDTH];

	svgpi_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_valid),
		.op_kind  (b_kind),
		.op_a     (b_a),
		.op_b     (b_b),
		.op_pop   (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind (m_tuser),
		.out_x    (px),
		.out_y    (py)
	);

	assign m_tdata = {py, px};

endmodule
